/* design/rslru_pkg.sv */
`default_nettype none

package rslru_pkg;

    localparam int SLOTS_DEF    = 64;
    localparam int PIN_BITS_DEF = 8;

    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int SIZE_W   = 20;
    localparam int TIME_W   = 48;
    localparam int STATUS_W = 3;
    localparam int MASK_W   = 64;
    localparam int CNT_W    = 7;
    localparam int BUDGET_W = 26;
    localparam int CFG_IDX_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ACQUIRE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EVICT      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EVICT_IDLE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LOAD_FAILED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESIDENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VRAM     = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] ram_size;
        logic [SIZE_W-1:0] vram_size;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] idle_limit;
        logic              load_ok;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MASK_W-1:0]   evicted_mask;
        logic [CNT_W-1:0]    evicted_count;
        logic                loaded;
    } result_t;

    typedef struct packed {
        logic load_item;
        logic do_register;
        logic capture;
        logic pin_inc;
        logic release_pin;
        logic evict_slot;
        logic acquire_load;
        logic scan_go;
        logic evict_best;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic in_range;
        logic is_registered;
        logic is_resident;
        logic pinned;
        logic pin_full;
        logic load_ok;
        logic fits;
        logic scan_busy;
        logic best_valid;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/rslru_datapath.sv */
`default_nettype none

module rslru_datapath #(
    parameter int SLOTS    = rslru_pkg::SLOTS_DEF,
    parameter int PIN_BITS = rslru_pkg::PIN_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rslru_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [rslru_pkg::BUDGET_W-1:0] cfg_data,
    input  wire rslru_pkg::item_t               item,
    input  wire rslru_pkg::dp_cmd_t             cmd,
    output rslru_pkg::dp_stat_t                 stat,
    output logic [rslru_pkg::MASK_W-1:0]        evicted_mask,
    output logic [rslru_pkg::CNT_W-1:0]         evicted_count
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
    localparam int TW = rslru_pkg::TIME_W;
    localparam int SW = rslru_pkg::SIZE_W;
    localparam int BW = rslru_pkg::BUDGET_W;
    localparam int CW = rslru_pkg::CNT_W;

    rslru_pkg::item_t item_reg;

    logic [CW-1:0] max_res_reg;
    logic [BW-1:0] max_ram_reg;
    logic [BW-1:0] max_vram_reg;

    logic [SLOTS-1:0] registered_reg;
    logic [SLOTS-1:0] resident_reg;
    logic [SLOTS-1:0] pinned_reg;
    logic [SLOTS-1:0] lu_valid_reg;

    logic [PIN_BITS-1:0] pin_mem  [SLOTS];
    logic [TW-1:0]       lu_mem   [SLOTS];
    logic [SW-1:0]       ram_mem  [SLOTS];
    logic [SW-1:0]       vram_mem [SLOTS];

    logic [PIN_BITS-1:0] pin_q;
    logic [TW-1:0]       lu_q;
    logic [SW-1:0]       ram_q;
    logic [SW-1:0]       vram_q;
    logic [IDX_W-1:0]    q_idx_reg;
    logic                q_valid_reg;

    logic             scan_on_reg;
    logic [IDX_W-1:0] scan_idx_reg;

    logic [PIN_BITS-1:0] s_pin_reg;
    logic [SW-1:0]       s_ram_reg;
    logic [SW-1:0]       s_vram_reg;

    logic             best_valid_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [TW-1:0]    best_lu_reg;
    logic [SW-1:0]    best_ram_reg;
    logic [SW-1:0]    best_vram_reg;

    logic [CW-1:0] cnt_total_reg;
    logic [BW-1:0] ram_total_reg;
    logic [BW-1:0] vram_total_reg;

    logic [rslru_pkg::MASK_W-1:0] mask_reg;
    logic [CW-1:0]                evcnt_reg;

    logic [IDX_W-1:0]    s_idx;
    logic [IDX_W-1:0]    rd_addr;
    logic [PIN_BITS-1:0] q_pin;
    logic [TW-1:0]       q_lu;
    logic                sweep;
    logic                victim_cand;
    logic                idle_hit;
    logic                unl_en;
    logic [IDX_W-1:0]    unl_idx;
    logic [SW-1:0]       unl_ram;
    logic [SW-1:0]       unl_vram;
    logic                pin_we;
    logic [PIN_BITS-1:0] pin_wd;
    logic                pin_nz;
    logic                lu_we;
    logic [BW:0]         ram_need;
    logic [BW:0]         vram_need;
    logic [CW:0]         cnt_need;

    assign s_idx   = item_reg.slot[IDX_W-1:0];
    assign rd_addr = scan_on_reg ? scan_idx_reg : s_idx;
    assign q_pin   = pinned_reg[q_idx_reg] ? pin_q : '0;
    assign q_lu    = lu_valid_reg[q_idx_reg] ? lu_q : '0;
    assign sweep   = (item_reg.mode == rslru_pkg::MODE_EVICT_IDLE);

    assign victim_cand = q_valid_reg && !sweep && resident_reg[q_idx_reg]
                         && !pinned_reg[q_idx_reg] && (q_idx_reg != s_idx);
    assign idle_hit = q_valid_reg && sweep && registered_reg[q_idx_reg]
                      && resident_reg[q_idx_reg] && !pinned_reg[q_idx_reg]
                      && (item_reg.now >= q_lu)
                      && ((item_reg.now - q_lu) >= item_reg.idle_limit);

    // at most one unload per cycle
    always_comb
    begin
        unl_en   = 1'b0;
        unl_idx  = q_idx_reg;
        unl_ram  = ram_q;
        unl_vram = vram_q;
        if (idle_hit)
        begin
            unl_en = 1'b1;
        end
        else if (cmd.evict_best)
        begin
            unl_en   = 1'b1;
            unl_idx  = best_idx_reg;
            unl_ram  = best_ram_reg;
            unl_vram = best_vram_reg;
        end
        else if (cmd.evict_slot && resident_reg[s_idx])
        begin
            unl_en  = 1'b1;
            unl_idx = s_idx;
        end
    end

    always_comb
    begin
        pin_we = 1'b0;
        pin_wd = q_pin;
        pin_nz = 1'b1;
        lu_we  = 1'b0;
        if (cmd.pin_inc)
        begin
            pin_we = 1'b1;
            pin_wd = q_pin + 1'b1;
        end
        else if (cmd.acquire_load)
        begin
            pin_we = 1'b1;
            pin_wd = s_pin_reg + 1'b1;
            lu_we  = 1'b1;
        end
        else if (cmd.release_pin)
        begin
            pin_we = 1'b1;
            pin_wd = (q_pin == '0) ? '0 : q_pin - 1'b1;
            pin_nz = (q_pin > PIN_BITS'(1));
            lu_we  = 1'b1;
        end
    end

    assign cnt_need  = {1'b0, cnt_total_reg} + (CW+1)'(1);
    assign ram_need  = {1'b0, ram_total_reg} + (BW+1)'(s_ram_reg);
    assign vram_need = {1'b0, vram_total_reg} + (BW+1)'(s_vram_reg);

    always_comb
    begin
        stat.mode          = item_reg.mode;
        stat.in_range      = ({1'b0, item_reg.slot} < (rslru_pkg::SLOT_W+1)'(SLOTS));
        stat.is_registered = registered_reg[s_idx];
        stat.is_resident   = resident_reg[s_idx];
        stat.pinned        = pinned_reg[s_idx];
        stat.pin_full      = (q_pin == PIN_MAX);
        stat.load_ok       = item_reg.load_ok;
        stat.fits          = ((max_res_reg == '0) || (cnt_need <= {1'b0, max_res_reg}))
                             && ((max_ram_reg == '0) || (ram_need <= {1'b0, max_ram_reg}))
                             && ((max_vram_reg == '0)
                                 || (vram_need <= {1'b0, max_vram_reg}));
        stat.scan_busy     = scan_on_reg || q_valid_reg;
        stat.best_valid    = best_valid_reg;
    end

    assign evicted_mask  = mask_reg;
    assign evicted_count = evcnt_reg;

    // memories: one write port at the item's slot, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.do_register)
        begin
            ram_mem[s_idx]  <= item_reg.ram_size;
            vram_mem[s_idx] <= item_reg.vram_size;
        end
        if (pin_we)
        begin
            pin_mem[s_idx] <= pin_wd;
        end
        if (lu_we)
        begin
            lu_mem[s_idx] <= item_reg.now;
        end
        pin_q     <= pin_mem[rd_addr];
        lu_q      <= lu_mem[rd_addr];
        ram_q     <= ram_mem[rd_addr];
        vram_q    <= vram_mem[rd_addr];
        q_idx_reg <= rd_addr;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.capture)
        begin
            s_pin_reg  <= q_pin;
            s_ram_reg  <= ram_q;
            s_vram_reg <= vram_q;
        end
        if (victim_cand && (!best_valid_reg || (q_lu < best_lu_reg)))
        begin
            best_idx_reg  <= q_idx_reg;
            best_lu_reg   <= q_lu;
            best_ram_reg  <= ram_q;
            best_vram_reg <= vram_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_res_reg    <= '0;
            max_ram_reg    <= '0;
            max_vram_reg   <= '0;
            registered_reg <= '0;
            resident_reg   <= '0;
            pinned_reg     <= '0;
            lu_valid_reg   <= '0;
            q_valid_reg    <= 1'b0;
            scan_on_reg    <= 1'b0;
            scan_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
            cnt_total_reg  <= '0;
            ram_total_reg  <= '0;
            vram_total_reg <= '0;
            mask_reg       <= '0;
            evcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    rslru_pkg::CFG_MAX_RESIDENT: max_res_reg  <= cfg_data[CW-1:0];
                    rslru_pkg::CFG_MAX_RAM:      max_ram_reg  <= cfg_data;
                    rslru_pkg::CFG_MAX_VRAM:     max_vram_reg <= cfg_data;
                    default: ;
                endcase
            end

            // scan sweep: issue one address a cycle
            q_valid_reg <= scan_on_reg;
            if (cmd.scan_go)
            begin
                scan_on_reg    <= 1'b1;
                scan_idx_reg   <= '0;
                best_valid_reg <= 1'b0;
            end
            else if (scan_on_reg)
            begin
                if (scan_idx_reg == IDX_W'(SLOTS - 1))
                begin
                    scan_on_reg <= 1'b0;
                end
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (victim_cand)
            begin
                best_valid_reg <= 1'b1;
            end

            if (cmd.load_item)
            begin
                mask_reg  <= '0;
                evcnt_reg <= '0;
            end
            if (cmd.do_register)
            begin
                registered_reg[s_idx] <= 1'b1;
            end
            if (pin_we)
            begin
                pinned_reg[s_idx] <= pin_nz;
            end
            if (lu_we)
            begin
                lu_valid_reg[s_idx] <= 1'b1;
            end

            if (cmd.acquire_load)
            begin
                resident_reg[s_idx] <= 1'b1;
                cnt_total_reg       <= cnt_total_reg + 1'b1;
                ram_total_reg       <= ram_total_reg + BW'(s_ram_reg);
                vram_total_reg      <= vram_total_reg + BW'(s_vram_reg);
            end
            else if (unl_en)
            begin
                resident_reg[unl_idx] <= 1'b0;
                cnt_total_reg         <= cnt_total_reg - 1'b1;
                ram_total_reg         <= ram_total_reg - BW'(unl_ram);
                vram_total_reg        <= vram_total_reg - BW'(unl_vram);
                mask_reg              <= mask_reg
                                         | (rslru_pkg::MASK_W'(1) << unl_idx);
                evcnt_reg             <= evcnt_reg + 1'b1;
            end
        end
    end

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_total_reg == CW'($countones(resident_reg)))
        else $error("resident count out of step with resident flags");

    a_resident_registered: assert property (@(posedge clk) disable iff (!rst_n)
        (resident_reg & ~registered_reg) == '0)
        else $error("resident slot that is not registered");

    a_pinned_resident: assert property (@(posedge clk) disable iff (!rst_n)
        (pinned_reg & ~resident_reg) == '0)
        else $error("pinned slot that is not resident");

    a_victim_unpinned: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict_best |-> (best_valid_reg && !pinned_reg[best_idx_reg]
                            && resident_reg[best_idx_reg]))
        else $error("victim is not an unpinned resident slot");

endmodule

`default_nettype wire

/* design/rslru_ctrl.sv */
`default_nettype none

module rslru_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    output logic                               done,
    output logic [rslru_pkg::STATUS_W-1:0]     status,
    output logic                               loaded,
    output rslru_pkg::dp_cmd_t                 cmd,
    input  wire rslru_pkg::dp_stat_t           stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_OPER,
        S_CHECK,
        S_SEARCH,
        S_SWEEP
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic                          done_reg;
    logic [rslru_pkg::STATUS_W-1:0] status_reg;
    logic                          loaded_reg;
    logic                          fin;
    logic [rslru_pkg::STATUS_W-1:0] fin_status;
    logic                          fin_loaded;

    always_comb
    begin
        state_next = state_reg;
        fin        = 1'b0;
        fin_status = rslru_pkg::ST_OK;
        fin_loaded = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.mode == rslru_pkg::MODE_REGISTER)
                begin
                    fin = 1'b1;
                    if (!stat.in_range)
                    begin
                        fin_status = rslru_pkg::ST_LIMIT;
                    end
                    else if (stat.is_registered)
                    begin
                        fin_status = rslru_pkg::ST_INVALID;
                    end
                    else
                    begin
                        cmd.do_register = 1'b1;
                    end
                end
                else if (stat.mode == rslru_pkg::MODE_EVICT_IDLE)
                begin
                    cmd.scan_go = 1'b1;
                    state_next  = S_SWEEP;
                end
                else if (stat.mode > rslru_pkg::MODE_EVICT_IDLE)
                begin
                    fin        = 1'b1;
                    fin_status = rslru_pkg::ST_INVALID;
                end
                else if (!stat.in_range || !stat.is_registered)
                begin
                    fin        = 1'b1;
                    fin_status = rslru_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    state_next = S_OPER;
                end
            end
            S_OPER:
            begin
                cmd.capture = 1'b1;
                if (stat.mode == rslru_pkg::MODE_ACQUIRE)
                begin
                    if (stat.pin_full)
                    begin
                        fin        = 1'b1;
                        fin_status = rslru_pkg::ST_BUSY;
                    end
                    else if (stat.is_resident)
                    begin
                        cmd.pin_inc = 1'b1;
                        fin         = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else if (stat.mode == rslru_pkg::MODE_RELEASE)
                begin
                    cmd.release_pin = 1'b1;
                    fin             = 1'b1;
                end
                else
                begin
                    fin = 1'b1;
                    if (stat.pinned)
                    begin
                        fin_status = rslru_pkg::ST_BUSY;
                    end
                    else
                    begin
                        cmd.evict_slot = 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.fits)
                begin
                    fin = 1'b1;
                    if (stat.load_ok)
                    begin
                        cmd.acquire_load = 1'b1;
                        fin_loaded       = 1'b1;
                    end
                    else
                    begin
                        fin_status = rslru_pkg::ST_LOAD_FAILED;
                    end
                end
                else
                begin
                    cmd.scan_go = 1'b1;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!stat.scan_busy)
                begin
                    if (stat.best_valid)
                    begin
                        cmd.evict_best = 1'b1;
                        state_next     = S_CHECK;
                    end
                    else
                    begin
                        fin        = 1'b1;
                        fin_status = rslru_pkg::ST_LIMIT;
                    end
                end
            end
            S_SWEEP:
            begin
                if (!stat.scan_busy)
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= rslru_pkg::ST_OK;
            loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (fin)
            begin
                status_reg <= fin_status;
                loaded_reg <= fin_loaded;
            end
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign loaded = loaded_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

endmodule

`default_nettype wire

/* design/resident_slot_lru_evictor.sv */
`default_nettype none

// Slot table with least-recently-used eviction under count, RAM and VRAM
// budgets. An item is taken when start is high while busy is low; its one
// result appears on result for exactly one cycle with done high and must be
// taken then, as the receiver cannot stall. Register, invalid and not-found
// items finish in the dispatch state; release and evict items finish in the
// operate state. Evict idle scans the whole table through the slot memories'
// single read port. An acquire that must make room makes one full pass of
// the last-use memory per victim search. Limit registers are written through
// cfg_we / cfg_idx / cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. The resident totals are
// kept in running sums so each capacity check is one compare.
module resident_slot_lru_evictor #(
    parameter int SLOTS    = rslru_pkg::SLOTS_DEF,
    parameter int PIN_BITS = rslru_pkg::PIN_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire rslru_pkg::item_t                item,
    output logic                                 done,
    output rslru_pkg::result_t                   result,
    input  wire logic                            cfg_we,
    input  wire logic [rslru_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [rslru_pkg::BUDGET_W-1:0]  cfg_data
);

    rslru_pkg::dp_cmd_t  cmd;
    rslru_pkg::dp_stat_t stat;
    logic [rslru_pkg::STATUS_W-1:0] status;
    logic                           loaded;
    logic [rslru_pkg::MASK_W-1:0]   evicted_mask;
    logic [rslru_pkg::CNT_W-1:0]    evicted_count;

    // sequencer: decodes the item and steps the victim search
    rslru_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .loaded (loaded),
        .cmd    (cmd),
        .stat   (stat)
    );

    // slot flags, slot memories, running totals and the scan engine
    rslru_datapath #(
        .SLOTS    (SLOTS),
        .PIN_BITS (PIN_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .item          (item),
        .cmd           (cmd),
        .stat          (stat),
        .evicted_mask  (evicted_mask),
        .evicted_count (evicted_count)
    );

    // mask and count hold from the last unload until the next item is taken
    always_comb
    begin
        result.status        = status;
        result.evicted_mask  = evicted_mask;
        result.evicted_count = evicted_count;
        result.loaded        = loaded;
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT     = rslru_pkg::SLOTS_DEF;
    localparam int PIN_TOP   = (1 << rslru_pkg::PIN_BITS_DEF) - 1;
    localparam int ITEM_BITS = $bits(rslru_pkg::item_t);

    // Shadow of the slot table plus the queue of results still owed by the block.
    class evictor_scoreboard;
        logic [rslru_pkg::CNT_W-1:0]        lim_count;
        logic [rslru_pkg::BUDGET_W-1:0]     lim_ram;
        logic [rslru_pkg::BUDGET_W-1:0]     lim_vram;
        bit                                 is_reg [NSLOT];
        bit                                 is_res [NSLOT];
        logic [rslru_pkg::PIN_BITS_DEF-1:0] pins [NSLOT];
        logic [rslru_pkg::TIME_W-1:0]       stamp [NSLOT];
        logic [rslru_pkg::SIZE_W-1:0]       ram_mb [NSLOT];
        logic [rslru_pkg::SIZE_W-1:0]       vram_mb [NSLOT];
        rslru_pkg::result_t                 owed [$];
        int                                 mismatches;

        function new();
            lim_count = '0;
            lim_ram = '0;
            lim_vram = '0;
            mismatches = 0;
            for (int i = 0; i < NSLOT; i++)
            begin
                is_reg[i] = 0;
                is_res[i] = 0;
                pins[i] = '0;
                stamp[i] = '0;
                ram_mb[i] = '0;
                vram_mb[i] = '0;
            end
        endfunction

        function void set_limit(logic [rslru_pkg::CFG_IDX_W-1:0] idx,
                                logic [rslru_pkg::BUDGET_W-1:0] val);
            if (idx == rslru_pkg::CFG_MAX_RESIDENT) lim_count = val[rslru_pkg::CNT_W-1:0];
            else if (idx == rslru_pkg::CFG_MAX_RAM) lim_ram = val;
            else if (idx == rslru_pkg::CFG_MAX_VRAM) lim_vram = val;
        endfunction

        // would the incoming slot fit next to everything already resident
        function bit room_for(int inc);
            longint unsigned n, ram, vram;
            n = 1;
            ram = ram_mb[inc];
            vram = vram_mb[inc];
            for (int i = 0; i < NSLOT; i++)
            begin
                if (i == inc || !is_res[i]) continue;
                n++;
                ram += ram_mb[i];
                vram += vram_mb[i];
            end
            return (lim_count == 0 || n <= lim_count) &&
                   (lim_ram == 0 || ram <= lim_ram) &&
                   (lim_vram == 0 || vram <= lim_vram);
        endfunction

        function void unload(int i, ref rslru_pkg::result_t r);
            if (!is_res[i]) return;
            is_res[i] = 0;
            r.evicted_mask[i] = 1'b1;
            r.evicted_count++;
        endfunction

        function void note_item(rslru_pkg::item_t it);
            rslru_pkg::result_t r;
            int s, v;
            r = '0;
            r.status = rslru_pkg::ST_OK;
            s = it.slot;
            if (it.mode == rslru_pkg::MODE_REGISTER)
            begin
                if (is_reg[s]) r.status = rslru_pkg::ST_INVALID;
                else
                begin
                    is_reg[s] = 1;
                    ram_mb[s] = it.ram_size;
                    vram_mb[s] = it.vram_size;
                end
            end
            else if (it.mode == rslru_pkg::MODE_EVICT_IDLE)
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (is_reg[i] && is_res[i] && pins[i] == 0 && it.now >= stamp[i] &&
                        it.now - stamp[i] >= it.idle_limit)
                        unload(i, r);
            end
            else if (it.mode > rslru_pkg::MODE_EVICT_IDLE) r.status = rslru_pkg::ST_INVALID;
            else if (!is_reg[s]) r.status = rslru_pkg::ST_NOT_FOUND;
            else if (it.mode == rslru_pkg::MODE_ACQUIRE)
            begin
                if (pins[s] >= PIN_TOP) r.status = rslru_pkg::ST_BUSY;
                else
                begin
                    if (!is_res[s])
                    begin
                        while (!room_for(s))
                        begin
                            v = NSLOT;
                            // oldest unpinned resident, lowest index on ties
                            for (int i = 0; i < NSLOT; i++)
                            begin
                                if (!is_res[i] || pins[i] != 0 || i == s) continue;
                                if (v == NSLOT || stamp[i] < stamp[v]) v = i;
                            end
                            if (v == NSLOT)
                            begin
                                r.status = rslru_pkg::ST_LIMIT;
                                break;
                            end
                            unload(v, r);
                        end
                        if (r.status == rslru_pkg::ST_OK)
                        begin
                            if (!it.load_ok) r.status = rslru_pkg::ST_LOAD_FAILED;
                            else
                            begin
                                is_res[s] = 1;
                                stamp[s] = it.now;
                                r.loaded = 1'b1;
                            end
                        end
                    end
                    if (r.status == rslru_pkg::ST_OK) pins[s]++;
                end
            end
            else if (it.mode == rslru_pkg::MODE_RELEASE)
            begin
                if (pins[s] > 0) pins[s]--;
                stamp[s] = it.now;
            end
            else
            begin
                if (pins[s] != 0) r.status = rslru_pkg::ST_BUSY;
                else unload(s, r);
            end
            owed.push_back(r);
        endfunction

        function void check_result(rslru_pkg::result_t got);
            rslru_pkg::result_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.evicted_mask !== want.evicted_mask ||
                got.evicted_count !== want.evicted_count || got.loaded !== want.loaded)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status %0d/%0d mask %h/%h count %0d/%0d loaded %0d/%0d",
                             want.status, got.status, want.evicted_mask, got.evicted_mask,
                             want.evicted_count, got.evicted_count, want.loaded, got.loaded);
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    rslru_pkg::item_t                    item;
    logic                                done;
    rslru_pkg::result_t                  result;
    logic                                cfg_we;
    logic [rslru_pkg::CFG_IDX_W-1:0]     cfg_idx;
    logic [rslru_pkg::BUDGET_W-1:0]      cfg_data;

    evictor_scoreboard sb;
    logic [rslru_pkg::TIME_W-1:0] tnow;   // running clock for stimulus timestamps

    resident_slot_lru_evictor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // results cannot be held off: every strobe is checked on the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1 && sb != null)
            sb.check_result(result);
    end

    // Hold start high until the item goes in, then optionally idle. Start is only
    // lowered when a gap follows, so back-to-back items keep it high.
    task automatic send(rslru_pkg::item_t it, int gap);
        item <= it;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_item(it);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic rslru_pkg::item_t make_item(logic [rslru_pkg::MODE_W-1:0] m, int s,
                                                   logic ok);
        rslru_pkg::item_t it;
        it = '0;
        it.mode = m;
        it.slot = s[rslru_pkg::SLOT_W-1:0];
        it.now = tnow;
        it.load_ok = ok;
        return it;
    endfunction

    // wait until every owed result is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0 || busy) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_limits(int n, int ram, int vram);
        cfg_we <= 1'b1;
        cfg_idx <= rslru_pkg::CFG_MAX_RESIDENT;
        cfg_data <= rslru_pkg::BUDGET_W'(n);
        sb.set_limit(rslru_pkg::CFG_MAX_RESIDENT, rslru_pkg::BUDGET_W'(n));
        @(posedge clk);
        cfg_idx <= rslru_pkg::CFG_MAX_RAM;
        cfg_data <= rslru_pkg::BUDGET_W'(ram);
        sb.set_limit(rslru_pkg::CFG_MAX_RAM, rslru_pkg::BUDGET_W'(ram));
        @(posedge clk);
        cfg_idx <= rslru_pkg::CFG_MAX_VRAM;
        cfg_data <= rslru_pkg::BUDGET_W'(vram);
        sb.set_limit(rslru_pkg::CFG_MAX_VRAM, rslru_pkg::BUDGET_W'(vram));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly acquire/release traffic on registered slots, with a tail of noise.
    function automatic rslru_pkg::item_t random_item();
        rslru_pkg::item_t it;
        int r, s;
        r = $urandom_range(0, 99);
        s = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 47) : $urandom_range(0, NSLOT - 1);
        if ($urandom_range(0, 99) < 3) tnow = rslru_pkg::TIME_W'({$urandom, $urandom});
        else tnow = tnow + $urandom_range(0, 50);
        it = make_item(rslru_pkg::MODE_ACQUIRE, s, $urandom_range(0, 99) < 90);
        if (r < 6) it.mode = rslru_pkg::MODE_REGISTER;
        else if (r < 44) it.mode = rslru_pkg::MODE_ACQUIRE;
        else if (r < 82) it.mode = rslru_pkg::MODE_RELEASE;
        else if (r < 90) it.mode = rslru_pkg::MODE_EVICT;
        else if (r < 96) it.mode = rslru_pkg::MODE_EVICT_IDLE;
        else it.mode = rslru_pkg::MODE_W'($urandom_range(5, 7));
        it.ram_size = ($urandom_range(0, 9) == 0) ? rslru_pkg::SIZE_W'($urandom)
                                                  : rslru_pkg::SIZE_W'($urandom_range(0, 1500));
        it.vram_size = ($urandom_range(0, 9) == 0) ? rslru_pkg::SIZE_W'($urandom)
                                                   : rslru_pkg::SIZE_W'($urandom_range(0, 1500));
        it.idle_limit = ($urandom_range(0, 9) == 0)
                        ? rslru_pkg::TIME_W'({$urandom, $urandom})
                        : rslru_pkg::TIME_W'($urandom_range(0, 300));
        if (r == 99) it = ITEM_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
        return it;
    endfunction

    initial
    begin
        rslru_pkg::item_t it;
        int    ph_cnt  [7] = '{64, 4, 1, 0, 0, 6, 0};
        int    ph_ram  [7] = '{67108863, 0, 0, 3000, 0, 4000, 0};
        int    ph_vram [7] = '{67108863, 0, 0, 0, 2500, 4000, 0};

        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        tnow = 48'd100;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes and special cases
        it = make_item(rslru_pkg::MODE_REGISTER, 0, 1'b1);
        it.ram_size = '1;
        it.vram_size = '1;
        send(it, 0);
        it = make_item(rslru_pkg::MODE_REGISTER, NSLOT - 1, 1'b1);
        send(it, 1);
        send(make_item(rslru_pkg::MODE_REGISTER, 0, 1'b1), 0);     // already registered
        send(make_item(rslru_pkg::MODE_ACQUIRE, 5, 1'b1), 0);      // not registered
        send(make_item(rslru_pkg::MODE_RELEASE, 5, 1'b1), 0);
        send(make_item(rslru_pkg::MODE_EVICT, 5, 1'b1), 0);
        for (int m = 5; m < 8; m++)
        begin
            it = '1;
            it.mode = rslru_pkg::MODE_W'(m);                        // unknown mode
            send(it, 0);
        end
        send(make_item(rslru_pkg::MODE_ACQUIRE, 0, 1'b0), 2);      // load failure
        send(make_item(rslru_pkg::MODE_ACQUIRE, 0, 1'b1), 0);
        send(make_item(rslru_pkg::MODE_ACQUIRE, 0, 1'b1), 0);      // already resident
        send(make_item(rslru_pkg::MODE_EVICT, 0, 1'b1), 0);        // pinned
        send(make_item(rslru_pkg::MODE_RELEASE, 0, 1'b1), 0);
        tnow = 48'd50;
        send(make_item(rslru_pkg::MODE_RELEASE, 0, 1'b1), 0);
        send(make_item(rslru_pkg::MODE_RELEASE, 0, 1'b1), 0);      // pin already zero
        send(make_item(rslru_pkg::MODE_ACQUIRE, NSLOT - 1, 1'b1), 0);
        send(make_item(rslru_pkg::MODE_RELEASE, NSLOT - 1, 1'b1), 0);
        tnow = 48'd10;
        it = make_item(rslru_pkg::MODE_EVICT_IDLE, 0, 1'b1);       // now before last use
        send(it, 0);
        tnow = '1;
        it = make_item(rslru_pkg::MODE_EVICT_IDLE, 0, 1'b1);
        it.idle_limit = '1;
        send(it, 0);
        it.idle_limit = '0;
        send(it, 0);
        send(make_item(rslru_pkg::MODE_EVICT, 0, 1'b1), 0);        // not resident
        tnow = 48'd1000;

        // populate most of the table so the limits have something to work on
        for (int s = 1; s < 48; s++)
        begin
            it = make_item(rslru_pkg::MODE_REGISTER, s, 1'b1);
            it.ram_size = rslru_pkg::SIZE_W'($urandom_range(0, 1500));
            it.vram_size = rslru_pkg::SIZE_W'($urandom_range(0, 1500));
            send(it, pick_gap());
        end

        // pin count saturation on one slot, then unwind it
        for (int k = 0; k <= PIN_TOP; k++)
            send(make_item(rslru_pkg::MODE_ACQUIRE, 1, 1'b1), 0);
        for (int k = 0; k <= PIN_TOP; k++)
            send(make_item(rslru_pkg::MODE_RELEASE, 1, 1'b1), 0);

        // sender holds back until everything is back, then the limits change
        for (int p = 0; p < 7; p++)
        begin
            drain();
            set_limits(ph_cnt[p], ph_ram[p], ph_vram[p]);
            for (int k = 0; k < 24; k++)
            begin
                if (k > 8 && k < 20) send(random_item(), 0);   // stretch with no gaps
                else send(random_item(), pick_gap());
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

/* resident_slot_lru_evictor.f */
design/rslru_pkg.sv
design/rslru_datapath.sv
design/rslru_ctrl.sv
design/resident_slot_lru_evictor.sv
tb/tb_top.sv
